// ----- rtl/pagerank_power_iteration_macros.svh -----
// assertion macros for the pagerank engine checker
// expects a clock named clk and an active low reset rst_n in scope
`ifndef PAGERANK_POWER_ITERATION_MACROS_SVH
`define PAGERANK_POWER_ITERATION_MACROS_SVH
// same cycle implication, off during reset
`define PGR_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("pgr assertion failed");
// next cycle implication, also active in reset
`define PGR_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("pgr assertion failed");
`endif

// ----- rtl/pgr_pkg.sv -----
// shared widths, codes and types for the pagerank engine
// no dependencies
package pgr_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NCNT_W    = NODE_W + 1;
  localparam int EDGE_W    = $clog2(MAX_EDGES);
  localparam int ECNT_W    = EDGE_W + 1;
  localparam int WGT_W     = 32;
  localparam int RANK_W    = 32;
  localparam int DEG_W     = 48;
  localparam int DVD_W     = 64;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [2:0] CFG_NODES    = 3'd0;
  localparam logic [2:0] CFG_DAMPING  = 3'd1;
  localparam logic [2:0] CFG_DIRECTED = 3'd2;
  localparam logic [2:0] CFG_WEIGHTED = 3'd3;
  localparam logic [2:0] CFG_PASSES   = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DEG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;
endpackage

// ----- rtl/pgr_div.sv -----
// bit serial restoring divider, one quotient bit per cycle
// depends on pgr_pkg
module pgr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pgr_pkg::div_req_t req,
  output pgr_pkg::div_rsp_t rsp
);
  localparam int CW = $clog2(pgr_pkg::DVD_W) + 1;

  logic [pgr_pkg::DEG_W-1:0] rem_r;
  logic [pgr_pkg::DEG_W-1:0] dsr_r;
  logic [pgr_pkg::DVD_W-1:0] quo_r;
  logic [CW-1:0]             cnt_r;
  logic                      run_r;
  logic                      done_r;
  logic [pgr_pkg::DEG_W:0]   trial;
  logic [pgr_pkg::DEG_W:0]   diff;
  logic                      bit_q;

  always_comb begin
    trial = {rem_r, quo_r[pgr_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    bit_q = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        dsr_r <= req.divisor;
        quo_r <= req.dividend;
      end else if (run_r) begin
        rem_r <= bit_q ? diff[pgr_pkg::DEG_W-1:0] : trial[pgr_pkg::DEG_W-1:0];
        quo_r <= {quo_r[pgr_pkg::DVD_W-2:0], bit_q};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(pgr_pkg::DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

// ----- rtl/pagerank_power_iteration.sv -----
// pagerank engine top level: edge list memory, node memory and run sequencer
// depends on pgr_pkg and pgr_div
//
// channel   handshake          fields
// input     start & !busy      in_kind in_src_node in_dst_node in_edge_weight in_read_node
// result    out_valid (1 cyc)  out_rank_value out_status
// config    cfg_we             cfg_index cfg_data
//
// clear and add answer in the cycle after the request, read answers from S_READ after the node memory read
// run: the serial divider gives the initial rank, the base term and each edge's rank term,
// and each undirected edge is walked in both directions
// reset is synchronous; no clearing pass, nodes beyond the largest count run so far read zero
// results cannot be stalled, each shows for one cycle
module pagerank_power_iteration (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_kind,
  input  logic [pgr_pkg::NODE_W-1:0]  in_src_node,
  input  logic [pgr_pkg::NODE_W-1:0]  in_dst_node,
  input  logic [pgr_pkg::WGT_W-1:0]   in_edge_weight,
  input  logic [pgr_pkg::NODE_W-1:0]  in_read_node,
  output logic                        out_valid,
  output logic [pgr_pkg::RANK_W-1:0]  out_rank_value,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);
  localparam int NW = pgr_pkg::NODE_W;
  localparam int NC = pgr_pkg::NCNT_W;
  localparam int EW = pgr_pkg::EDGE_W;
  localparam int EC = pgr_pkg::ECNT_W;
  localparam int WW = pgr_pkg::WGT_W;
  localparam int RW = pgr_pkg::RANK_W;
  localparam int DW = pgr_pkg::DEG_W;

  typedef struct packed {
    logic [RW-1:0] rank;
    logic [RW-1:0] acc;
    logic [DW-1:0] deg;
  } node_t;

  typedef struct packed {
    logic [NW-1:0] src;
    logic [NW-1:0] dst;
    logic [WW-1:0] wgt;
  } edge_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_DIVI_GO, S_DIVI_W, S_DIVB_GO, S_DIVB_W, S_INIT,
    S_EDGE, S_EWAIT, S_NRD, S_NWAIT, S_DIV_GO, S_DIV_W, S_ARD, S_AWAIT,
    S_NEXT, S_FIN, S_FWAIT, S_FMUL, S_FWR, S_DONE
  } state_t;

  // configuration
  logic [NC-1:0] node_count_r;
  logic [15:0]   damping_r;
  logic          directed_r;
  logic          weighted_r;
  logic [7:0]    passes_r;

  state_t        state_r;
  logic [EC-1:0] edge_total_r;
  logic [NC-1:0] filled_r;
  logic [EC-1:0] e_r;
  logic [NW-1:0] v_r;
  logic [7:0]    pass_r;
  logic          phase_r;
  logic          dir_r;
  logic [NW-1:0] from_r;
  logic [NW-1:0] to_r;
  logic [WW-1:0] w_r;
  logic [63:0]   prod_r;
  logic [DW-1:0] deg_r;
  logic [RW-1:0] term_r;
  logic [RW-1:0] init_r;
  logic [RW-1:0] base_r;
  logic [47:0]   mul_r;
  logic [NW-1:0] rd_node_r;
  logic          rd_range_r;

  logic          out_valid_r;
  logic [RW-1:0] out_rank_r;
  logic [1:0]    out_status_r;

  // memories
  edge_t         edge_mem [pgr_pkg::MAX_EDGES];
  node_t         node_mem [pgr_pkg::MAX_NODES];
  edge_t         edge_q_r;
  node_t         node_q_r;

  logic          edge_re, edge_we, node_re, node_we;
  logic [EW-1:0] edge_ra, edge_wa;
  logic [NW-1:0] node_ra, node_wa;
  edge_t         edge_wd;
  node_t         node_wd;

  pgr_pkg::div_req_t div_req;
  pgr_pkg::div_rsp_t div_rsp;

  logic [NC-1:0] n_eff, n_m1;
  logic          accept, add_range, add_full;
  logic          last_v, edge_out;
  logic [WW-1:0] w_eff;
  logic [DW:0]   deg_sum;
  logic [RW:0]   acc_sum;
  logic [RW:0]   rank_sum;
  logic [RW-1:0] rank_new;
  logic [16:0]   one_m_d;

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NC'(1);
    end else if (node_count_r > NC'(pgr_pkg::MAX_NODES)) begin
      n_eff = NC'(pgr_pkg::MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
    n_m1      = n_eff - 1'b1;
    last_v    = ({1'b0, v_r} == n_m1);
    accept    = start && (state_r == S_IDLE);
    add_range = ({1'b0, in_src_node} >= n_eff) || ({1'b0, in_dst_node} >= n_eff);
    add_full  = edge_total_r[EW];
    edge_out  = ({1'b0, edge_q_r.src} >= n_eff) || ({1'b0, edge_q_r.dst} >= n_eff);
    w_eff     = weighted_r ? edge_q_r.wgt : WW'(32'h10000);
    deg_sum   = {1'b0, node_q_r.deg} + {{(DW - WW + 1){1'b0}}, w_r};
    acc_sum   = {1'b0, node_q_r.acc} + {1'b0, term_r};
    rank_sum  = {1'b0, base_r} + {1'b0, mul_r[47:16]};
    rank_new  = rank_sum[RW] ? '1 : rank_sum[RW-1:0];
    one_m_d   = 17'h10000 - {1'b0, damping_r};
  end

  // memory controls
  always_comb begin
    edge_re = 1'b0;
    edge_ra = e_r[EW-1:0];
    edge_we = accept && (in_kind == pgr_pkg::KIND_ADD) && !add_range && !add_full;
    edge_wa = edge_total_r[EW-1:0];
    edge_wd = '{src: in_src_node, dst: in_dst_node, wgt: in_edge_weight};
    node_re = 1'b0;
    node_ra = v_r;
    node_we = 1'b0;
    node_wa = v_r;
    node_wd = node_q_r;
    div_req = '{start: 1'b0, dividend: '0, divisor: '0};
    case (state_r)
      S_IDLE: begin
        node_re = accept && (in_kind == pgr_pkg::KIND_READ);
        node_ra = in_read_node;
      end
      S_DIVI_GO: begin
        div_req = '{start: 1'b1, dividend: 64'h8000_0000, divisor: DW'(n_eff)};
      end
      S_DIVB_GO: begin
        div_req = '{start: 1'b1, dividend: 64'({one_m_d, 15'd0}), divisor: DW'(n_eff)};
      end
      S_DIV_GO: begin
        div_req = '{start: 1'b1, dividend: prod_r, divisor: deg_r};
      end
      S_INIT: begin
        node_we = 1'b1;
        node_wd = '{rank: init_r, acc: '0, deg: '0};
      end
      S_EDGE: edge_re = (e_r != edge_total_r);
      S_NRD: begin
        node_re = 1'b1;
        node_ra = from_r;
      end
      S_NWAIT: begin
        node_we = !phase_r;
        node_wa = from_r;
        node_wd.deg = deg_sum[DW] ? '1 : deg_sum[DW-1:0];
      end
      S_ARD: begin
        node_re = 1'b1;
        node_ra = to_r;
      end
      S_AWAIT: begin
        node_we = 1'b1;
        node_wa = to_r;
        node_wd.acc = acc_sum[RW] ? '1 : acc_sum[RW-1:0];
      end
      S_FIN: node_re = 1'b1;
      S_FWR: begin
        node_we = 1'b1;
        node_wd.rank = rank_new;
        node_wd.acc = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (edge_re) edge_q_r <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) node_q_r <= node_mem[node_ra];
  end

  pgr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NC'(1);
      damping_r    <= 16'd55706;
      directed_r   <= 1'b1;
      weighted_r   <= 1'b0;
      passes_r     <= 8'd105;
      edge_total_r <= '0;
      filled_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          pgr_pkg::CFG_NODES:    node_count_r <= cfg_data[NC-1:0];
          pgr_pkg::CFG_DAMPING:  damping_r    <= cfg_data;
          pgr_pkg::CFG_DIRECTED: directed_r   <= cfg_data[0];
          pgr_pkg::CFG_WEIGHTED: weighted_r   <= cfg_data[0];
          pgr_pkg::CFG_PASSES:   passes_r     <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_rank_r   <= '0;
            out_status_r <= pgr_pkg::ST_OK;
            case (in_kind)
              pgr_pkg::KIND_CLEAR: begin
                edge_total_r <= '0;
                out_valid_r  <= 1'b1;
              end
              pgr_pkg::KIND_ADD: begin
                out_valid_r <= 1'b1;
                if (add_range) begin
                  out_status_r <= pgr_pkg::ST_RANGE;
                end else if (add_full) begin
                  out_status_r <= pgr_pkg::ST_FULL;
                end else begin
                  edge_total_r <= edge_total_r + 1'b1;
                end
              end
              pgr_pkg::KIND_RUN: begin
                if (n_eff > filled_r) filled_r <= n_eff;
                state_r <= S_DIVI_GO;
              end
              default: begin
                rd_node_r  <= in_read_node;
                rd_range_r <= ({1'b0, in_read_node} >= n_eff);
                state_r    <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          if (rd_range_r) begin
            out_status_r <= pgr_pkg::ST_RANGE;
          end else if ({1'b0, rd_node_r} < filled_r) begin
            out_rank_r <= node_q_r.rank;
          end
          state_r <= S_IDLE;
        end
        S_DIVI_GO: state_r <= S_DIVI_W;
        S_DIVI_W: begin
          if (div_rsp.done) begin
            init_r  <= div_rsp.quotient[RW-1:0];
            state_r <= S_DIVB_GO;
          end
        end
        S_DIVB_GO: state_r <= S_DIVB_W;
        S_DIVB_W: begin
          if (div_rsp.done) begin
            base_r  <= div_rsp.quotient[RW-1:0];
            v_r     <= '0;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          v_r <= v_r + 1'b1;
          if (last_v) begin
            e_r     <= '0;
            phase_r <= 1'b0;
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (e_r == edge_total_r) begin
            if (phase_r) begin
              v_r     <= '0;
              state_r <= S_FIN;
            end else if (passes_r == 8'd0) begin
              state_r <= S_DONE;
            end else begin
              phase_r <= 1'b1;
              pass_r  <= '0;
              e_r     <= '0;
            end
          end else begin
            state_r <= S_EWAIT;
          end
        end
        S_EWAIT: begin
          if (edge_out) begin
            e_r     <= e_r + 1'b1;
            state_r <= S_EDGE;
          end else begin
            from_r  <= edge_q_r.src;
            to_r    <= edge_q_r.dst;
            w_r     <= w_eff;
            dir_r   <= 1'b0;
            state_r <= S_NRD;
          end
        end
        S_NRD: state_r <= S_NWAIT;
        S_NWAIT: begin
          if (!phase_r || (node_q_r.deg == '0)) begin
            state_r <= S_NEXT;
          end else begin
            prod_r  <= w_r * node_q_r.rank;
            deg_r   <= node_q_r.deg;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_W;
        S_DIV_W: begin
          if (div_rsp.done) begin
            term_r  <= div_rsp.quotient[RW-1:0];
            state_r <= S_ARD;
          end
        end
        S_ARD: state_r <= S_AWAIT;
        S_AWAIT: state_r <= S_NEXT;
        S_NEXT: begin
          if (!directed_r && !dir_r) begin
            dir_r   <= 1'b1;
            from_r  <= to_r;
            to_r    <= from_r;
            state_r <= S_NRD;
          end else begin
            e_r     <= e_r + 1'b1;
            state_r <= S_EDGE;
          end
        end
        S_FIN: state_r <= S_FWAIT;
        S_FWAIT: state_r <= S_FMUL;
        S_FMUL: begin
          mul_r   <= damping_r * node_q_r.acc;
          state_r <= S_FWR;
        end
        S_FWR: begin
          v_r <= v_r + 1'b1;
          if (!last_v) begin
            state_r <= S_FIN;
          end else if (pass_r + 8'd1 == passes_r) begin
            state_r <= S_DONE;
          end else begin
            pass_r  <= pass_r + 8'd1;
            e_r     <= '0;
            state_r <= S_EDGE;
          end
        end
        S_DONE: begin
          out_valid_r  <= 1'b1;
          out_rank_r   <= '0;
          out_status_r <= pgr_pkg::ST_OK;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_rank_value = out_rank_r;
  assign out_status     = out_status_r;
endmodule

// ----- rtl/pgr_chk.sv -----
// port level checker for the pagerank engine, bound to the top level
// depends on pgr_pkg and pagerank_power_iteration_macros.svh
`include "pagerank_power_iteration_macros.svh"
module pgr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_rank_value,
  input logic [1:0]  out_status
);
  // no unused status code
  `PGR_ASSERT_IMP(a_status_code, out_valid, out_status != pgr_pkg::ST_BAD)
  // a rank only comes with an ok status
  `PGR_ASSERT_IMP(a_rank_ok, out_valid && (out_rank_value != 32'd0), out_status == pgr_pkg::ST_OK)
  // reset leaves the block idle and silent
  `PGR_ASSERT_NXT(a_reset_idle, !rst_n, !busy && !out_valid)
  // a taken request is answered next cycle or keeps the block busy
  `PGR_ASSERT_NXT(a_req_progress, rst_n && start && !busy, !rst_n || out_valid || busy)
endmodule

bind pagerank_power_iteration pgr_chk u_pgr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_rank_value(out_rank_value),
  .out_status    (out_status)
);
